/* hdl/tdbl_pkg.sv */
// ============================================================================
// tdbl_pkg: shared types and constants for the tree distance block
// Widths, table sizes, item layouts and the mode codes used by the top level
// and the lifting core.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package tdbl_pkg;

    // Field widths and table sizes.
    localparam int NODE_W    = 10;
    localparam int DIST_W    = 11;
    localparam int MAX_NODES = 1024;
    localparam int LEVELS    = 11;
    localparam int LVL_W     = 4;
    localparam int ANC_AW    = LVL_W + NODE_W;
    localparam int ANC_DEPTH = LEVELS * MAX_NODES;

    // Mode codes of an input item.
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_BUILD = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // Input item.
    typedef struct packed {
        logic [1:0]        mode;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [NODE_W-1:0] parent_node;
        logic [NODE_W-1:0] node_depth;
    } item_t;

    // Result item.
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [NODE_W-1:0] common_ancestor;
    } result_t;

    // Control from the top level to the core.
    typedef struct packed {
        logic start;
        logic res_ready;
    } core_ctrl_t;

    // Status from the core to the top level.
    typedef struct packed {
        logic idle;
        logic res_valid;
    } core_status_t;

endpackage

`default_nettype wire

/* hdl/tdbl_core.sv */
// ============================================================================
// tdbl_core: sequencer, tables and shared adder of the tree distance block
// Holds the ancestor and depth memories and steps one item at a time through
// load, table build or query, using a single add/subtract unit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tdbl_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tdbl_pkg::core_ctrl_t         ctrl,
    input  wire tdbl_pkg::item_t              item,
    input  wire logic [tdbl_pkg::NODE_W-1:0]  node_count,
    output tdbl_pkg::core_status_t            status,
    output tdbl_pkg::result_t                 result
);
    import tdbl_pkg::*;

    typedef enum logic [20:0] {
        ST_IDLE      = 21'h000001,
        ST_DISPATCH  = 21'h000002,
        ST_B_RD1     = 21'h000004,
        ST_B_RD2     = 21'h000008,
        ST_B_WR      = 21'h000010,
        ST_Q_DB      = 21'h000020,
        ST_Q_DIFF    = 21'h000040,
        ST_Q_DIFF2   = 21'h000080,
        ST_LIFT      = 21'h000100,
        ST_LIFT_WAIT = 21'h000200,
        ST_Q_EQ      = 21'h000400,
        ST_C_RA      = 21'h000800,
        ST_C_RB      = 21'h001000,
        ST_C_CMP     = 21'h002000,
        ST_F_TOP     = 21'h004000,
        ST_F_TWAIT   = 21'h008000,
        ST_F_DA      = 21'h010000,
        ST_F_DB      = 21'h020000,
        ST_F_DT1     = 21'h040000,
        ST_F_DT2     = 21'h080000,
        ST_DONE      = 21'h100000
    } state_t;

    state_t              state_reg, state_next;
    item_t               item_reg, item_next;
    logic [NODE_W-1:0]   a_reg, a_next;
    logic [NODE_W-1:0]   b_reg, b_next;
    logic [NODE_W-1:0]   n_reg, n_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [NODE_W-1:0]   steps_reg, steps_next;
    logic                lift_b_reg, lift_b_next;
    logic [NODE_W-1:0]   val_reg, val_next;
    logic [NODE_W-1:0]   x_reg, x_next;
    logic [NODE_W-1:0]   top_reg, top_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;

    // Memory ports.
    logic                anc_re;
    logic [NODE_W-1:0]   anc_rnode;
    logic [LVL_W-1:0]    anc_rlvl;
    logic                anc_we;
    logic [NODE_W-1:0]   anc_wnode;
    logic [LVL_W-1:0]    anc_wlvl;
    logic [NODE_W-1:0]   anc_wdata;
    logic                dep_re;
    logic [NODE_W-1:0]   dep_rnode;
    logic                dep_we;
    logic [NODE_W-1:0]   dep_wnode;
    logic [NODE_W-1:0]   dep_wdata;

    logic [NODE_W-1:0]   anc_mem [ANC_DEPTH];
    logic [NODE_W-1:0]   dep_mem [MAX_NODES];
    logic [NODE_W-1:0]   anc_q_reg;
    logic                anc_zero_reg;
    logic [NODE_W-1:0]   dep_q_reg;
    logic                dep_zero_reg;
    logic [NODE_W-1:0]   anc_rd;
    logic [NODE_W-1:0]   dep_rd;

    // Shared add/subtract unit.
    logic [DIST_W-1:0]   alu_x;
    logic [DIST_W-1:0]   alu_y;
    logic                alu_sub;
    logic [DIST_W:0]     alu_sum;

    logic [NODE_W-1:0]   lift_node;

    // Node 0 has no ancestors and depth 0, whatever the memory holds for it.
    assign anc_rd = anc_zero_reg ? '0 : anc_q_reg;
    assign dep_rd = dep_zero_reg ? '0 : dep_q_reg;

    assign alu_sum = {1'b0, alu_x} + {1'b0, alu_y ^ {DIST_W{alu_sub}}}
                   + {{DIST_W{1'b0}}, alu_sub};

    assign lift_node = lift_b_reg ? b_reg : a_reg;

    // Ancestor memory: entry address is the level above the node number.
    always_ff @(posedge clk)
    begin
        if (anc_we)
        begin
            anc_mem[{anc_wlvl, anc_wnode}] <= anc_wdata;
        end
        if (anc_re)
        begin
            anc_q_reg    <= anc_mem[{anc_rlvl, anc_rnode}];
            anc_zero_reg <= (anc_rnode == '0);
        end
    end

    // Depth memory.
    always_ff @(posedge clk)
    begin
        if (dep_we)
        begin
            dep_mem[dep_wnode] <= dep_wdata;
        end
        if (dep_re)
        begin
            dep_q_reg    <= dep_mem[dep_rnode];
            dep_zero_reg <= (dep_rnode == '0);
        end
    end

    // Sequencer next-state and datapath.
    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        n_next      = n_reg;
        lvl_next    = lvl_reg;
        steps_next  = steps_reg;
        lift_b_next = lift_b_reg;
        val_next    = val_reg;
        x_next      = x_reg;
        top_next    = top_reg;
        dist_next   = dist_reg;

        anc_re    = 1'b0;
        anc_rnode = a_reg;
        anc_rlvl  = lvl_reg;
        anc_we    = 1'b0;
        anc_wnode = n_reg;
        anc_wlvl  = lvl_reg;
        anc_wdata = anc_rd;
        dep_re    = 1'b0;
        dep_rnode = a_reg;
        dep_we    = 1'b0;
        dep_wnode = item_reg.node_a;
        dep_wdata = item_reg.node_depth;

        alu_x   = dist_reg;
        alu_y   = {1'b0, dep_rd};
        alu_sub = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    item_next  = item;
                    a_next     = item.node_a;
                    b_next     = item.node_b;
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                case (item_reg.mode)
                    MODE_LOAD:
                    begin
                        // Node 0 is the fixed "no node" mark and is never stored.
                        if (item_reg.node_a != '0)
                        begin
                            anc_we    = 1'b1;
                            anc_wnode = item_reg.node_a;
                            anc_wlvl  = '0;
                            anc_wdata = item_reg.parent_node;
                            dep_we    = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                    MODE_BUILD:
                    begin
                        n_next   = NODE_W'(1);
                        lvl_next = LVL_W'(1);
                        if (node_count == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_B_RD1;
                        end
                    end
                    MODE_QUERY:
                    begin
                        dep_re     = 1'b1;
                        dep_rnode  = a_reg;
                        state_next = ST_Q_DB;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            // Build: read the level below for node n, then for that ancestor.
            ST_B_RD1:
            begin
                anc_re     = 1'b1;
                anc_rnode  = n_reg;
                anc_rlvl   = LVL_W'(lvl_reg - 1'b1);
                state_next = ST_B_RD2;
            end

            ST_B_RD2:
            begin
                anc_re     = 1'b1;
                anc_rnode  = anc_rd;
                anc_rlvl   = LVL_W'(lvl_reg - 1'b1);
                state_next = ST_B_WR;
            end

            // Write the entry and, unless n is the last node, start the next node's first read.
            ST_B_WR:
            begin
                anc_we    = 1'b1;
                anc_wnode = n_reg;
                anc_wlvl  = lvl_reg;
                anc_wdata = anc_rd;
                if (n_reg == node_count)
                begin
                    if (lvl_reg == LVL_W'(LEVELS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        lvl_next   = LVL_W'(lvl_reg + 1'b1);
                        n_next     = NODE_W'(1);
                        state_next = ST_B_RD1;
                    end
                end
                else
                begin
                    n_next     = NODE_W'(n_reg + 1'b1);
                    anc_re     = 1'b1;
                    anc_rnode  = NODE_W'(n_reg + 1'b1);
                    anc_rlvl   = LVL_W'(lvl_reg - 1'b1);
                    state_next = ST_B_RD2;
                end
            end

            // Query: fetch both depths.
            ST_Q_DB:
            begin
                val_next   = dep_rd;
                dep_re     = 1'b1;
                dep_rnode  = b_reg;
                state_next = ST_Q_DIFF;
            end

            // Depth of a minus depth of b; a borrow means b is deeper.
            ST_Q_DIFF:
            begin
                alu_x    = {1'b0, val_reg};
                alu_y    = {1'b0, dep_rd};
                alu_sub  = 1'b1;
                lvl_next = '0;
                if (alu_sum[DIST_W])
                begin
                    dist_next   = alu_sum[DIST_W-1:0];
                    steps_next  = alu_sum[NODE_W-1:0];
                    lift_b_next = 1'b0;
                    state_next  = ST_LIFT;
                end
                else
                begin
                    state_next = ST_Q_DIFF2;
                end
            end

            ST_Q_DIFF2:
            begin
                alu_x       = {1'b0, dep_rd};
                alu_y       = {1'b0, val_reg};
                alu_sub     = 1'b1;
                dist_next   = alu_sum[DIST_W-1:0];
                steps_next  = alu_sum[NODE_W-1:0];
                lift_b_next = 1'b1;
                state_next  = ST_LIFT;
            end

            // Lift the deeper node one bit of the depth difference a step.
            ST_LIFT:
            begin
                if (steps_reg == '0)
                begin
                    state_next = ST_Q_EQ;
                end
                else if (steps_reg[0])
                begin
                    anc_re     = 1'b1;
                    anc_rnode  = lift_node;
                    anc_rlvl   = lvl_reg;
                    state_next = ST_LIFT_WAIT;
                end
                else
                begin
                    steps_next = steps_reg >> 1;
                    lvl_next   = LVL_W'(lvl_reg + 1'b1);
                end
            end

            ST_LIFT_WAIT:
            begin
                if (lift_b_reg)
                begin
                    b_next = anc_rd;
                end
                else
                begin
                    a_next = anc_rd;
                end
                steps_next = steps_reg >> 1;
                lvl_next   = LVL_W'(lvl_reg + 1'b1);
                state_next = ST_LIFT;
            end

            ST_Q_EQ:
            begin
                if (a_reg == b_reg)
                begin
                    top_next   = a_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    lvl_next   = LVL_W'(LEVELS - 1);
                    state_next = ST_C_RA;
                end
            end

            // Climb both nodes from the top level down.
            ST_C_RA:
            begin
                anc_re     = 1'b1;
                anc_rnode  = a_reg;
                anc_rlvl   = lvl_reg;
                state_next = ST_C_RB;
            end

            ST_C_RB:
            begin
                x_next     = anc_rd;
                anc_re     = 1'b1;
                anc_rnode  = b_reg;
                anc_rlvl   = lvl_reg;
                state_next = ST_C_CMP;
            end

            ST_C_CMP:
            begin
                if ((x_reg != '0) && (anc_rd != '0) && (x_reg != anc_rd))
                begin
                    a_next = x_reg;
                    b_next = anc_rd;
                end
                if (lvl_reg == '0)
                begin
                    state_next = ST_F_TOP;
                end
                else
                begin
                    lvl_next   = LVL_W'(lvl_reg - 1'b1);
                    state_next = ST_C_RA;
                end
            end

            // The ancestor is the parent of the climbed node a.
            ST_F_TOP:
            begin
                anc_re     = 1'b1;
                anc_rnode  = a_reg;
                anc_rlvl   = '0;
                state_next = ST_F_TWAIT;
            end

            ST_F_TWAIT:
            begin
                top_next   = anc_rd;
                dep_re     = 1'b1;
                dep_rnode  = a_reg;
                state_next = ST_F_DA;
            end

            // Accumulate depth a + depth b - 2 * depth of the ancestor.
            ST_F_DA:
            begin
                dist_next  = alu_sum[DIST_W-1:0];
                dep_re     = 1'b1;
                dep_rnode  = b_reg;
                state_next = ST_F_DB;
            end

            ST_F_DB:
            begin
                dist_next  = alu_sum[DIST_W-1:0];
                dep_re     = 1'b1;
                dep_rnode  = top_reg;
                state_next = ST_F_DT1;
            end

            ST_F_DT1:
            begin
                alu_sub    = 1'b1;
                dist_next  = alu_sum[DIST_W-1:0];
                state_next = ST_F_DT2;
            end

            ST_F_DT2:
            begin
                alu_sub    = 1'b1;
                dist_next  = alu_sum[DIST_W-1:0];
                state_next = ST_DONE;
            end

            // Hold the result until the output register can take it.
            ST_DONE:
            begin
                if (ctrl.res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            n_reg      <= '0;
            lvl_reg    <= '0;
            steps_reg  <= '0;
            lift_b_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            lvl_reg    <= lvl_next;
            steps_reg  <= steps_next;
            lift_b_reg <= lift_b_next;
        end
    end

    // Working values.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        val_reg  <= val_next;
        x_reg    <= x_next;
        top_reg  <= top_next;
        dist_reg <= dist_next;
    end

    assign status.idle            = (state_reg == ST_IDLE);
    assign status.res_valid       = (state_reg == ST_DONE);
    assign result.distance        = dist_reg;
    assign result.common_ancestor = top_reg;

endmodule

`default_nettype wire

/* hdl/tree_distance_binary_lifting.sv */
// ============================================================================
// tree_distance_binary_lifting: path length and lowest common ancestor
// Top level: input and configuration handshakes, node count register and the
// output register in front of the result channel.
// ============================================================================
// Usage:
//   The in channel takes one item at a time (valid/stall); in_stall is high
//   while an item is at work. Mode load writes one node's parent and depth,
//   mode build fills the ancestor levels for nodes 1..node_count, mode query
//   returns one item on the out channel with the distance and the ancestor.
//   Load and build items give no result.
//   A query lifts the deeper node one bit of the depth difference a step;
//   when the lifted nodes differ, it climbs both over all eleven levels,
//   reading each node's entry through the single read port of the ancestor
//   memory at each level. A result that cannot move to the output register
//   holds the core until it can. The config channel (valid/ready) writes
//   node_count; it is ready while no item is at work. Reset sets node_count
//   to 1 and empties the output register; the tables are not cleared and
//   need loading and a build. A finished result waits in the output register
//   while out_stall is high; the next item is taken meanwhile, and a second
//   result waits in the core.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tree_distance_binary_lifting (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire tdbl_pkg::item_t             in_item,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output tdbl_pkg::result_t                out_item,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [tdbl_pkg::NODE_W-1:0] cfg_data
);
    import tdbl_pkg::*;

    core_ctrl_t          ctrl;
    core_status_t        status;
    result_t             core_result;
    logic [NODE_W-1:0]   node_count_reg, node_count_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_item_reg, out_item_next;
    logic                out_free;

    // Handshakes.
    assign in_stall       = !status.idle;
    assign cfg_ready      = status.idle;
    assign out_free       = !out_valid_reg || !out_stall;
    assign ctrl.start     = in_valid && status.idle;
    assign ctrl.res_ready = out_free;

    tdbl_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .item       (in_item),
        .node_count (node_count_reg),
        .status     (status),
        .result     (core_result)
    );

    // Node count register and output register next values.
    always_comb
    begin
        node_count_next = node_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            node_count_next = cfg_data;
        end

        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;
        if (status.res_valid && out_free)
        begin
            out_valid_next = 1'b1;
            out_item_next  = core_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_W'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            node_count_reg <= node_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // An accepted item keeps the core busy in the next cycle.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("core not busy after an accepted item");

    // The core only offers a result while it is not idle.
    a_result_not_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        status.res_valid |-> !status.idle
    ) else $error("core offers a result while idle");

    // A result handed over shows up on the output in the next cycle.
    a_result_lands: assert property (
        @(posedge clk) disable iff (!rst_n)
        (status.res_valid && ctrl.res_ready) |=> out_valid
    ) else $error("handed over result missing on the output");

endmodule

`default_nettype wire
